// ===== rtl/ftbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbt_pkg
// shared types and constants of the fraction to balanced ternary converter
// ----------------------------------------------------------------------------
package ftbt_pkg;

	localparam int FIELD_BITS     = 32;
	localparam int VALUE_BITS     = 32;
	localparam int MAX_INT_TRITS  = 22;
	localparam int MAX_FRAC_TRITS = 20;
	localparam int TOTAL_TRITS    = MAX_INT_TRITS + MAX_FRAC_TRITS;
	localparam int TRIT_BITS      = 2;

	localparam logic [TRIT_BITS-1:0] TRIT_ZERO  = 2'd0;
	localparam logic [TRIT_BITS-1:0] TRIT_PLUS  = 2'd1;
	localparam logic [TRIT_BITS-1:0] TRIT_MINUS = 2'd2;

	typedef struct packed {
		logic [FIELD_BITS-1:0] numerator;
		logic [FIELD_BITS-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic [TRIT_BITS-1:0] trit;
		logic                 fraction_start;
		logic                 last;
	} res_t;

endpackage

// ===== rtl/ftbt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbt_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ftbt_ram #(
	parameter int WIDTH = ftbt_pkg::TRIT_BITS,
	parameter int DEPTH = ftbt_pkg::TOTAL_TRITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ftbt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ftbt_div #(
	parameter int VALUE_BITS = ftbt_pkg::VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] r_q;
	logic [VALUE_BITS-1:0] q_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS+1:0] diff;
	logic                  ge;

	assign trial = {r_q, q_q[VALUE_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign ge    = ~diff[VALUE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
			q_q <= {q_q[VALUE_BITS-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

// ===== rtl/ftbt_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbt_gcd
// binary gcd, one shift or subtract step per cycle
// ----------------------------------------------------------------------------
module ftbt_gcd #(
	parameter int VALUE_BITS = ftbt_pkg::VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] op_a,
	input  logic [VALUE_BITS-1:0] op_b,
	output logic                  done,
	output logic [VALUE_BITS-1:0] gcd
);

	localparam int KW = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [VALUE_BITS-1:0] a_q;
	logic [VALUE_BITS-1:0] b_q;
	logic [KW-1:0]         k_q;
	logic [VALUE_BITS-1:0] g_q;
	logic [VALUE_BITS:0]   d_ab;
	logic [VALUE_BITS-1:0] d_ba;
	logic                  equal;

	assign d_ab  = {1'b0, a_q} - {1'b0, b_q};
	assign d_ba  = b_q - a_q;
	assign equal = (a_q == b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && equal) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (equal) begin
				g_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (!d_ab[VALUE_BITS]) begin
				a_q <= d_ab[VALUE_BITS:1];
			end else begin
				b_q <= {1'b0, d_ba[VALUE_BITS-1:1]};
			end
		end
	end

	assign done = done_q;
	assign gcd  = g_q;

endmodule

// ===== rtl/ftbt_div3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbt_div3
// divide by three, eight dividend bits per cycle, most significant first
// ----------------------------------------------------------------------------
module ftbt_div3 #(
	parameter int VALUE_BITS = ftbt_pkg::VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [1:0]            remainder
);

	localparam int CHUNK = 8;
	localparam int STEPS = (VALUE_BITS + CHUNK - 1) / CHUNK;
	localparam int PADW  = STEPS * CHUNK;
	localparam int CW    = $clog2(STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [PADW-1:0]  x_q;
	logic [1:0]       r_q;
	logic [CHUNK-1:0] q_chunk;
	logic [1:0]       r_next;

	always_comb begin
		logic [1:0] r;
		logic [2:0] t;
		logic [CHUNK-1:0] top;
		top     = x_q[PADW-1 -: CHUNK];
		r       = r_q;
		q_chunk = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			t = {r, top[i]};
			if (t >= 3'd3) begin
				q_chunk[i] = 1'b1;
				t          = t - 3'd3;
			end
			r = t[1:0];
		end
		r_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= PADW'(value);
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= (x_q << CHUNK) | PADW'(q_chunk);
			r_q <= r_next;
		end
	end

	assign done      = done_q;
	assign quotient  = x_q[VALUE_BITS-1:0];
	assign remainder = r_q;

endmodule

// ===== rtl/fraction_to_balanced_ternary.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_to_balanced_ternary
// converts numerator/divisor to balanced ternary digits, most significant first
// ----------------------------------------------------------------------------
// usage:
//  - a transaction is taken at a rising edge with start high and busy low;
//    request carries numerator and divisor (a zero divisor acts as one)
//  - busy stays high until the last digit has been delivered
//  - each digit appears on result for one cycle with result_valid high;
//    fraction_start marks the first digit after the radix point, last marks
//    the final digit; digits come out on consecutive cycles
//  - the receiver cannot stall: every digit must be taken as it appears
//  - sequence: one restoring division, then for a nonzero remainder a binary
//    gcd, two further divisions and a count of fraction digits; each digit
//    then passes through the divide-by-three unit, and the stored digits
//    are emitted last
//  - the divider, the gcd unit and the divide-by-three unit set how long a transaction takes
//  - reset aborts any conversion and returns the block to idle
// ----------------------------------------------------------------------------
module fraction_to_balanced_ternary #(
	parameter int VALUE_BITS     = ftbt_pkg::VALUE_BITS,
	parameter int MAX_INT_TRITS  = ftbt_pkg::MAX_INT_TRITS,
	parameter int MAX_FRAC_TRITS = ftbt_pkg::MAX_FRAC_TRITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ftbt_pkg::req_t  request,
	output logic            result_valid,
	output ftbt_pkg::res_t  result
);

	localparam int TOTAL = MAX_INT_TRITS + MAX_FRAC_TRITS;
	localparam int PW    = $clog2(TOTAL + 1);
	localparam int AW    = $clog2(TOTAL);
	localparam int FLW   = $clog2(MAX_FRAC_TRITS + 1);
	localparam int ILW   = $clog2(MAX_INT_TRITS + 1);
	localparam int VB    = VALUE_BITS;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_DIV  = 10'b0000000010,
		S_GCD  = 10'b0000000100,
		S_RDIV = 10'b0000001000,
		S_FDIV = 10'b0000010000,
		S_FLEN = 10'b0000100000,
		S_FDIG = 10'b0001000000,
		S_IDIG = 10'b0010000000,
		S_TOP  = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t                      state_q;
	logic                        run_q;
	logic                        carry_q;
	logic [PW-1:0]               wptr_q;
	logic [PW-1:0]               rptr_q;
	logic [FLW-1:0]              flen_q;
	logic [ILW-1:0]              ilen_q;
	logic                        valid_s1;
	logic [PW-1:0]               idx_s1;
	logic [VB-1:0]               den_q;
	logic [VB-1:0]               quo_q;
	logic [VB-1:0]               rem_q;
	logic [VB-1:0]               g_q;
	logic [VB-1:0]               rd_q;
	logic [VB-1:0]               val_q;
	logic [VB+1:0]               pow_q;

	logic                        accept;
	logic [VB-1:0]               num_in;
	logic [VB-1:0]               den_in;
	logic                        div_start;
	logic [VB-1:0]               div_dividend;
	logic [VB-1:0]               div_divisor;
	logic                        div_done;
	logic [VB-1:0]               div_quo;
	logic [VB-1:0]               div_rem;
	logic                        gcd_start;
	logic                        gcd_done;
	logic [VB-1:0]               gcd_val;
	logic                        d3_start;
	logic                        d3_done;
	logic [VB-1:0]               d3_quo;
	logic [1:0]                  d3_rem;
	logic [VB+1:0]               pow3;
	logic                        flen_more;
	logic                        int_more;
	logic                        top_digit;
	logic [2:0]                  trit_sum;
	logic [1:0]                  trit_val;
	logic                        trit_carry;
	logic [ftbt_pkg::TRIT_BITS-1:0] trit_code;
	logic                        ram_we;
	logic [ftbt_pkg::TRIT_BITS-1:0] ram_wdata;
	logic [ftbt_pkg::TRIT_BITS-1:0] ram_rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE) || valid_s1;
	assign num_in = VB'(request.numerator);
	assign den_in = (VB'(request.divisor) == '0) ? VB'(1) : VB'(request.divisor);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = num_in;
		div_divisor  = den_in;
		if (state_q == S_IDLE) begin
			div_start = accept;
		end else if (state_q == S_RDIV) begin
			div_start    = !run_q;
			div_dividend = den_q;
			div_divisor  = g_q;
		end else if (state_q == S_FDIV) begin
			div_start    = !run_q;
			div_dividend = rem_q;
			div_divisor  = g_q;
		end
	end

	assign gcd_start = (state_q == S_GCD) && !run_q;

	assign pow3      = pow_q + (pow_q << 1);
	assign flen_more = (flen_q < FLW'(MAX_FRAC_TRITS)) && (pow3 <= {2'b00, rd_q});
	assign int_more  = ((ilen_q == '0) || (val_q != '0)) && (ilen_q < ILW'(MAX_INT_TRITS));
	assign top_digit = carry_q && (ilen_q < ILW'(MAX_INT_TRITS));

	assign d3_start = !run_q && (((state_q == S_FDIG) && (wptr_q != PW'(flen_q)))
		|| ((state_q == S_IDIG) && int_more));

	// add one plus carry to the new digit
	assign trit_sum   = {1'b0, d3_rem} + 3'd1 + {2'b00, carry_q};
	assign trit_carry = (trit_sum >= 3'd3);
	assign trit_val   = trit_carry ? 2'(trit_sum - 3'd3) : trit_sum[1:0];

	always_comb begin
		unique case (trit_val)
			2'd0:    trit_code = ftbt_pkg::TRIT_MINUS;
			2'd1:    trit_code = ftbt_pkg::TRIT_ZERO;
			default: trit_code = ftbt_pkg::TRIT_PLUS;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = trit_code;
		if (((state_q == S_FDIG) || (state_q == S_IDIG)) && run_q && d3_done) begin
			ram_we = 1'b1;
		end else if ((state_q == S_TOP) && top_digit) begin
			ram_we    = 1'b1;
			ram_wdata = ftbt_pkg::TRIT_PLUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
						run_q   <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						run_q   <= 1'b0;
						state_q <= (div_rem == '0) ? S_FDIG : S_GCD;
					end
				end
				S_GCD: begin
					if (!run_q) begin
						run_q <= 1'b1;
					end else if (gcd_done) begin
						run_q   <= 1'b0;
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					if (!run_q) begin
						run_q <= 1'b1;
					end else if (div_done) begin
						run_q   <= 1'b0;
						state_q <= S_FDIV;
					end
				end
				S_FDIV: begin
					if (!run_q) begin
						run_q <= 1'b1;
					end else if (div_done) begin
						run_q   <= 1'b0;
						state_q <= S_FLEN;
					end
				end
				S_FLEN: begin
					if (!flen_more) begin
						state_q <= S_FDIG;
					end
				end
				S_FDIG: begin
					if (!run_q) begin
						if (d3_start) begin
							run_q <= 1'b1;
						end else begin
							state_q <= S_IDIG;
						end
					end else if (d3_done) begin
						run_q <= 1'b0;
					end
				end
				S_IDIG: begin
					if (!run_q) begin
						if (d3_start) begin
							run_q <= 1'b1;
						end else begin
							state_q <= S_TOP;
						end
					end else if (d3_done) begin
						run_q <= 1'b0;
					end
				end
				S_TOP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					valid_s1 <= 1'b1;
					if (rptr_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					run_q   <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				den_q   <= den_in;
				wptr_q  <= '0;
				carry_q <= 1'b0;
				ilen_q  <= '0;
				flen_q  <= '0;
			end
			S_DIV: begin
				quo_q <= div_quo;
				rem_q <= div_rem;
				val_q <= div_quo;
			end
			S_GCD: begin
				g_q <= gcd_val;
			end
			S_RDIV: begin
				rd_q <= div_quo;
			end
			S_FDIV: begin
				val_q <= div_quo;
				pow_q <= (VB + 2)'(1);
			end
			S_FLEN: begin
				if (flen_more) begin
					pow_q  <= pow3;
					flen_q <= flen_q + FLW'(1);
				end
			end
			S_FDIG: begin
				if (!run_q && !d3_start) begin
					val_q <= quo_q;
				end else if (run_q && d3_done) begin
					val_q   <= d3_quo;
					carry_q <= trit_carry;
					wptr_q  <= wptr_q + PW'(1);
				end
			end
			S_IDIG: begin
				if (run_q && d3_done) begin
					val_q   <= d3_quo;
					carry_q <= trit_carry;
					wptr_q  <= wptr_q + PW'(1);
					ilen_q  <= ilen_q + ILW'(1);
				end
			end
			S_TOP: begin
				rptr_q <= top_digit ? wptr_q : wptr_q - PW'(1);
			end
			S_EMIT: begin
				rptr_q <= rptr_q - PW'(1);
				idx_s1 <= rptr_q;
			end
			default: begin
				rptr_q <= rptr_q;
			end
		endcase
	end

	ftbt_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	ftbt_gcd #(
		.VALUE_BITS(VALUE_BITS)
	) u_gcd (
		.clk   (clk),
		.arst_n(arst_n),
		.start (gcd_start),
		.op_a  (den_q),
		.op_b  (rem_q),
		.done  (gcd_done),
		.gcd   (gcd_val)
	);

	ftbt_div3 #(
		.VALUE_BITS(VALUE_BITS)
	) u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (d3_start),
		.value    (val_q),
		.done     (d3_done),
		.quotient (d3_quo),
		.remainder(d3_rem)
	);

	ftbt_ram #(
		.WIDTH(ftbt_pkg::TRIT_BITS),
		.DEPTH(TOTAL)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(rptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign result_valid          = valid_s1;
	assign result.trit           = ram_rdata;
	assign result.fraction_start = (flen_q != '0) && (PW'(flen_q) == idx_s1 + PW'(1));
	assign result.last           = (idx_s1 == '0);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transaction accepted but block not busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid && !busy)
		else $error("digits continue after the last digit");

	a_trit_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.trit == ftbt_pkg::TRIT_ZERO
			|| result.trit == ftbt_pkg::TRIT_PLUS || result.trit == ftbt_pkg::TRIT_MINUS))
		else $error("invalid digit code delivered");

	a_flen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		flen_q <= FLW'(MAX_FRAC_TRITS))
		else $error("fraction digit count beyond its limit");

	a_wptr_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> wptr_q < PW'(TOTAL))
		else $error("digit store written beyond its depth");
`endif

endmodule

// ===== tb/sv/fraction_to_balanced_ternary_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_to_balanced_ternary_tb
// self-checking bench for the fraction to balanced ternary converter: each
// accepted transaction is expanded into its expected digit sequence by a local
// model, and every digit strobed out is checked in order against it; directed
// corner cases come first, then random power-of-three and arbitrary fractions
// with random sender gaps
// ----------------------------------------------------------------------------
module fraction_to_balanced_ternary_tb;

	localparam int EXP_DEPTH = 256;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	ftbt_pkg::req_t request;
	logic           result_valid;
	ftbt_pkg::res_t result;

	ftbt_pkg::res_t expected_digits [EXP_DEPTH];
	int             exp_head;
	int             exp_tail;
	int             error_count;
	bit             no_gaps;

	fraction_to_balanced_ternary DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic int pending_digits();
		return exp_tail - exp_head;
	endfunction

	function automatic void add_expected(input ftbt_pkg::res_t d);
		expected_digits[exp_tail % EXP_DEPTH] = d;
		exp_tail++;
	endfunction

	function automatic ftbt_pkg::res_t take_expected();
		ftbt_pkg::res_t d;
		d = expected_digits[exp_head % EXP_DEPTH];
		exp_head++;
		return d;
	endfunction

	function automatic logic [31:0] pow3(input int k);
		logic [31:0] p;
		p = 32'd1;
		for (int i = 0; i < k; i++)
			p = p * 3;
		return p;
	endfunction

	// expands one fraction into its balanced digits, most significant first
	function automatic void predict_conversion(input ftbt_pkg::req_t r);
		logic [63:0]    num, den, quo, rem, frac, a, b, m, t;
		logic [1:0]     dig [ftbt_pkg::TOTAL_TRITS+1];
		int             flen, ilen, total, k, v;
		logic           carry;
		ftbt_pkg::res_t d;
		num   = r.numerator;
		den   = r.divisor;
		frac  = '0;
		flen  = 0;
		ilen  = 0;
		carry = 1'b0;
		if (den == 0)
			den = 1;
		quo = num / den;
		rem = num % den;
		if (rem != 0) begin
			a = den;
			b = rem;
			while (b != 0) begin
				m = a % b;
				a = b;
				b = m;
			end
			frac = rem / a;
			t    = (den / a) / 3;
			while (t != 0) begin
				t = t / 3;
				flen++;
			end
			if (flen > ftbt_pkg::MAX_FRAC_TRITS)
				flen = ftbt_pkg::MAX_FRAC_TRITS;
		end
		for (k = 0; k < flen; k++) begin
			dig[k] = 2'(frac % 3);
			frac   = frac / 3;
		end
		if (quo == 0) begin
			dig[flen] = 2'd0;
			ilen      = 1;
		end else begin
			while (quo != 0 && ilen < ftbt_pkg::MAX_INT_TRITS) begin
				dig[flen+ilen] = 2'(quo % 3);
				quo            = quo / 3;
				ilen++;
			end
		end
		total = flen + ilen;
		// add all-ones with a rippling carry
		for (k = 0; k < total; k++) begin
			v = int'(dig[k]) + 1 + int'(carry);
			if (v >= 3) begin
				v     = v - 3;
				carry = 1'b1;
			end else begin
				carry = 1'b0;
			end
			dig[k] = 2'(v);
		end
		if (carry && ilen < ftbt_pkg::MAX_INT_TRITS) begin
			dig[total] = 2'd2;
			ilen++;
			total++;
		end
		for (k = total - 1; k >= 0; k--) begin
			d.trit           = (dig[k] == 2'd0) ? ftbt_pkg::TRIT_MINUS :
			                   (dig[k] == 2'd1) ? ftbt_pkg::TRIT_ZERO : ftbt_pkg::TRIT_PLUS;
			d.fraction_start = (flen > 0 && k == flen - 1);
			d.last           = (k == 0);
			add_expected(d);
		end
	endfunction

	always @(posedge clk) begin
		ftbt_pkg::res_t want;
		if (arst_n && result_valid) begin
			if (pending_digits() == 0) begin
				report_mismatch($sformatf("unexpected digit trit=%0d frac=%0b last=%0b",
					result.trit, result.fraction_start, result.last));
			end else begin
				want = take_expected();
				if (result.trit !== want.trit || result.fraction_start !== want.fraction_start ||
				    result.last !== want.last)
					report_mismatch($sformatf(
						"trit %0d/%0d fraction_start %0b/%0b last %0b/%0b (got/want)",
						result.trit, want.trit, result.fraction_start, want.fraction_start,
						result.last, want.last));
			end
		end
	end

	task automatic send_conversion(input logic [31:0] numerator, input logic [31:0] divisor);
		int             gap;
		ftbt_pkg::req_t r;
		gap         = no_gaps ? 0 : $urandom_range(0, 7);
		r.numerator = numerator;
		r.divisor   = divisor;
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   = 1'b1;
		request = r;
		do @(posedge clk); while (busy);
		predict_conversion(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_digits() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		unique case ($urandom_range(0, 4))
			0:       return $urandom;
			1:       return $urandom_range(0, 100);
			2:       return $urandom >> $urandom_range(0, 31);
			3:       return ~($urandom_range(0, 15));
			default: return $urandom & $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_conversion(32'd0, 32'd1);
		send_conversion(32'd1, 32'd1);
		send_conversion(32'hFFFF_FFFF, 32'd1);
		send_conversion(32'd17, 32'd0);
		send_conversion(32'd0, 32'hFFFF_FFFF);
		send_conversion(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_conversion(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_conversion(32'd1, 32'd3);
		send_conversion(32'd2, 32'd3);
		send_conversion(32'd5, 32'd9);
		send_conversion(32'd8, 32'd9);
		send_conversion(32'd7, 32'd3);
		send_conversion(32'd13, 32'd1);
		send_conversion(32'd1743392200, 32'd1);
		send_conversion(32'd1, 32'd2);
		send_conversion(32'd4, 32'd6);
		send_conversion(32'd5, 32'd7);
		send_conversion(32'd1, pow3(20));
		send_conversion(pow3(20) - 1, pow3(20));
		send_conversion(32'hFFFF_FFFF, pow3(20));
		send_conversion(32'd1, 32'hFFFF_FFFE);
		send_conversion(32'd26, 32'd27);
		send_conversion(32'd100, 32'd81);
		wait_drained();
	endtask

	task automatic test_power_fractions(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 30)
				no_gaps = 1'b1;
			else if (i % 60 == 45)
				no_gaps = 1'b0;
			send_conversion(random_value(), pow3($urandom_range(0, 20)));
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_arbitrary_divisors(input int count);
		logic [31:0] den;
		for (int i = 0; i < count; i++) begin
			den = random_value();
			if (den == 0)
				den = $urandom_range(1, 50);
			send_conversion(random_value(), den);
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 6; i++)
			send_conversion($urandom, pow3($urandom_range(1, 20)));
		wait_drained();
		for (int i = 0; i < 6; i++)
			send_conversion($urandom_range(0, 1000), pow3($urandom_range(0, 6)));
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		exp_head    = 0;
		exp_tail    = 0;
		error_count = 0;
		no_gaps     = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_power_fractions(265);
		test_drain_pause();
		test_arbitrary_divisors(110);

		@(negedge clk);
		start = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (pending_digits() != 0)
			report_mismatch($sformatf("%0d digits never arrived", pending_digits()));
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
